### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/phtc_pkg.sv
package phtc_pkg;

  localparam int HEAD_W = 21;
  localparam int ERR_W = 22;
  localparam int DIFF_W = 23;
  localparam int INT_W = 32;
  localparam int SUM_W = 49;
  localparam int DRIVE_W = 14;

  localparam int MIN_TICKS_DEF = 10;
  localparam int SETTLE_TICKS_DEF = 10;

  localparam logic [0:0] ACT_START = 1'b0;
  localparam logic [0:0] ACT_TICK = 1'b1;

  localparam logic [0:0] REG_TARGET = 1'b0;
  localparam logic [0:0] REG_GAIN = 1'b1;

  // q24 gains
  localparam logic signed [25:0] KP0 = 26'sd20132659;
  localparam logic signed [10:0] KI0 = 11'sd839;
  localparam logic signed [24:0] KD0 = 25'sd15099494;
  localparam logic signed [25:0] KP1 = 26'sd16777216;
  localparam logic signed [10:0] KI1 = 11'sd336;
  localparam logic signed [24:0] KD1 = 25'sd15099494;

  localparam logic [ERR_W-1:0] TOL_STOP = 22'd10;
  localparam logic [ERR_W-1:0] TOL_ICLR_LO = 22'd50;
  localparam logic [ERR_W-1:0] TOL_ICLR_HI = 22'd10000;

  localparam logic [27:0] SAT_LIMIT = 28'd60005;
  localparam logic [16:0] RECIP5 = 17'd52429;
  localparam logic [DRIVE_W-1:0] DRIVE_MAX = 14'd12000;

  typedef struct packed {
    logic signed [HEAD_W-1:0] target;
    logic gain;
  } cfg_t;

  typedef struct packed {
    logic stop;
    logic gain;
    logic signed [ERR_W-1:0] err;
    logic signed [INT_W-1:0] integ;
    logic signed [DIFF_W-1:0] diff;
  } track_t;

  typedef struct packed {
    logic stop;
    logic signed [47:0] p_err;
    logic signed [42:0] p_int;
    logic signed [47:0] p_diff;
  } prod_t;

endpackage

### rtl/pid_heading_turn_controller_unit.sv
// heading pid turn controller
// input channel (in_valid/in_ready) carries action and measured_heading; an
// action of start clears the turn state, a tick runs one control step
// against target_heading. each transaction gives exactly one result on the
// output channel (out_valid/out_ready): drive_mv, turn_left and stop.
// configuration goes through the apb port: target_heading at 0x0, gain_set
// at 0x4; write only while no transaction is in flight.
// throughput: one transaction per cycle while the receiver keeps out_ready
// high, set by the turn state update in the tracking stage; the rest is a
// six-register pipeline (input, state, products, sum, scale, output).
// reset clears the turn state, sets target_heading and gain_set to zero and
// empties the pipeline.
// when the receiver stalls, results hold in the output register and the
// stages behind it keep filling empty slots; in_ready drops only once all
// six stages hold a transaction.
module pid_heading_turn_controller_unit
  import phtc_pkg::*;
#(
  parameter int MIN_TICKS = MIN_TICKS_DEF,
  parameter int SETTLE_TICKS = SETTLE_TICKS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     action,
  input  logic signed [HEAD_W-1:0] measured_heading,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [DRIVE_W-1:0]       drive_mv,
  output logic                     turn_left,
  output logic                     stop,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  cfg_t   cfg;
  track_t trk;
  prod_t  prod;

  logic                     act_q;
  logic signed [HEAD_W-1:0] head_q;
  logic [5:0]               vld;
  logic [5:0]               rdy;

  assign pready = 1'b1;

  always_comb begin
    rdy[5] = !vld[5] || out_ready;
    for (int k = 4; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];
  assign out_valid = vld[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < 6; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy[0]) begin
      act_q <= action;
      head_q <= measured_heading;
    end
  end

  phtc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  phtc_track #(
    .MIN_TICKS    (MIN_TICKS),
    .SETTLE_TICKS (SETTLE_TICKS)
  ) u_track (
    .clk     (clk),
    .rst     (rst),
    .load    (vld[0] && rdy[1]),
    .action  (act_q),
    .heading (head_q),
    .cfg     (cfg),
    .res     (trk)
  );

  phtc_mult u_mult (
    .clk  (clk),
    .load (vld[1] && rdy[2]),
    .trk  (trk),
    .prod (prod)
  );

  phtc_drive u_drive (
    .clk       (clk),
    .load      ({vld[4] && rdy[5], vld[3] && rdy[4], vld[2] && rdy[3]}),
    .prod      (prod),
    .drive_mv  (drive_mv),
    .turn_left (turn_left),
    .stop      (stop)
  );

endmodule

### rtl/phtc_cfg.sv
module phtc_cfg
  import phtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfg_t        cfg
);

  logic wr;

  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target <= '0;
      cfg.gain <= 1'b0;
    end else if (wr) begin
      case (paddr[2])
        REG_TARGET: cfg.target <= pwdata[HEAD_W-1:0];
        REG_GAIN: cfg.gain <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TARGET: prdata = 32'(cfg.target);
      REG_GAIN: prdata = {31'd0, cfg.gain};
      default: prdata = '0;
    endcase
  end

endmodule

### rtl/phtc_track.sv
module phtc_track
  import phtc_pkg::*;
#(
  parameter int MIN_TICKS = MIN_TICKS_DEF,
  parameter int SETTLE_TICKS = SETTLE_TICKS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  logic                     action,
  input  logic signed [HEAD_W-1:0] heading,
  input  cfg_t                     cfg,
  output track_t                   res
);

  localparam int TW = $clog2(MIN_TICKS + 2);
  localparam int SW = $clog2(SETTLE_TICKS + 1);

  logic signed [INT_W-1:0]  integ;
  logic signed [ERR_W-1:0]  last_err;
  logic [TW-1:0]            tick_cnt;
  logic [SW-1:0]            settle_cnt;
  logic                     finished;

  logic signed [ERR_W-1:0]  err;
  logic [ERR_W-1:0]         abs_err;
  logic signed [33:0]       integ_sum;
  logic signed [INT_W-1:0]  integ_next;
  logic signed [DIFF_W-1:0] diff;
  logic [TW-1:0]            tick_next;
  logic [SW-1:0]            settle_next;
  logic                     settled;

  always_comb begin
    err = ERR_W'(cfg.target) - ERR_W'(heading);
    abs_err = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    tick_next = (tick_cnt < TW'(MIN_TICKS + 1)) ? tick_cnt + 1'b1 : tick_cnt;
    integ_sum = 34'(integ) + 34'(err) * 34'sd15;
    if (!integ_sum[33] && integ_sum[32:31] != 2'b00) begin
      integ_next = {1'b0, {(INT_W-1){1'b1}}};
    end else if (integ_sum[33] && integ_sum[32:31] != 2'b11) begin
      integ_next = {1'b1, {(INT_W-1){1'b0}}};
    end else begin
      integ_next = integ_sum[INT_W-1:0];
    end
    if (abs_err <= TOL_ICLR_LO || abs_err >= TOL_ICLR_HI) begin
      integ_next = '0;
    end
    diff = DIFF_W'(err) - DIFF_W'(last_err);
    if (diff == DIFF_W'(-1) || diff == '0 || diff == DIFF_W'(1)) begin
      settle_next = (settle_cnt < SW'(SETTLE_TICKS)) ? settle_cnt + 1'b1 : settle_cnt;
    end else begin
      settle_next = '0;
    end
    settled = (tick_next > TW'(MIN_TICKS)) && (settle_next >= SW'(SETTLE_TICKS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
      last_err <= '0;
      tick_cnt <= '0;
      settle_cnt <= '0;
      finished <= 1'b0;
    end else if (load) begin
      if (action == ACT_START) begin
        integ <= '0;
        last_err <= '0;
        tick_cnt <= '0;
        settle_cnt <= '0;
        finished <= 1'b0;
      end else if (!finished) begin
        if (abs_err <= TOL_STOP) begin
          finished <= 1'b1;
        end else begin
          integ <= integ_next;
          last_err <= err;
          tick_cnt <= tick_next;
          settle_cnt <= settle_next;
          finished <= settled;
        end
      end
    end
  end

  // zeroed operands give zero drive and no turn direction
  always_ff @(posedge clk) begin
    if (load) begin
      res.gain <= cfg.gain;
      res.err <= '0;
      res.integ <= '0;
      res.diff <= '0;
      if (action == ACT_START) begin
        res.stop <= 1'b0;
      end else if (finished || abs_err <= TOL_STOP || settled) begin
        res.stop <= 1'b1;
      end else begin
        res.stop <= 1'b0;
        res.err <= err;
        res.integ <= integ_next;
        res.diff <= diff;
      end
    end
  end

endmodule

### rtl/phtc_mult.sv
module phtc_mult
  import phtc_pkg::*;
(
  input  logic   clk,
  input  logic   load,
  input  track_t trk,
  output prod_t  prod
);

  logic signed [25:0] kp;
  logic signed [10:0] ki;
  logic signed [24:0] kd;
  logic signed [47:0] p_err;
  logic signed [42:0] p_int;
  logic signed [47:0] p_diff;

  always_comb begin
    kp = trk.gain ? KP1 : KP0;
    ki = trk.gain ? KI1 : KI0;
    kd = trk.gain ? KD1 : KD0;
    p_err = trk.err * kp;
    p_int = trk.integ * ki;
    p_diff = trk.diff * kd;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod.stop <= trk.stop;
      prod.p_err <= p_err;
      prod.p_int <= p_int;
      prod.p_diff <= p_diff;
    end
  end

endmodule

### rtl/phtc_drive.sv
module phtc_drive
  import phtc_pkg::*;
(
  input  logic               clk,
  input  logic [2:0]         load,
  input  prod_t              prod,
  output logic [DRIVE_W-1:0] drive_mv,
  output logic               turn_left,
  output logic               stop
);

  logic signed [SUM_W-1:0] sum;
  logic                    sum_stop;
  logic [SUM_W-1:0]        mag;
  logic [51:0]             scaled;
  logic [15:0]             quo24;
  logic                    sat;
  logic                    neg;
  logic                    q_stop;
  logic [32:0]             recip;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      sum <= SUM_W'(prod.p_err) + SUM_W'(prod.p_int) + SUM_W'(prod.p_diff);
      sum_stop <= prod.stop;
    end
  end

  // round(|sum| * 6 / (5 * 2^24)), ties up
  always_comb begin
    mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    scaled = {mag, 2'b00} + {1'b0, mag, 1'b0} + 52'd41943040;
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      quo24 <= scaled[39:24];
      sat <= (scaled[51:24] >= SAT_LIMIT);
      neg <= sum[SUM_W-1];
      q_stop <= sum_stop;
    end
  end

  // divide by five through the reciprocal
  assign recip = quo24 * RECIP5;

  always_ff @(posedge clk) begin
    if (load[2]) begin
      drive_mv <= sat ? DRIVE_MAX : recip[31:18];
      turn_left <= neg;
      stop <= q_stop;
    end
  end

endmodule

### rtl/phtc_checker.sv
`include "assert_macros.svh"

module phtc_checker
  import phtc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DRIVE_W-1:0] drive_mv,
  input logic               turn_left,
  input logic               stop
);

  `CHK_SAME(a_stop_quiet, out_valid && stop, drive_mv == '0 && !turn_left)
  `CHK_SAME(a_drive_sat, out_valid, drive_mv <= DRIVE_MAX)
  `CHK_SAME(a_full_only_stalled, !in_ready, out_valid && !out_ready)
  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive_mv))

endmodule

bind pid_heading_turn_controller_unit phtc_checker u_phtc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .drive_mv  (drive_mv),
  .turn_left (turn_left),
  .stop      (stop)
);

### sim/tb_pid_heading_turn_controller_unit.sv
`timescale 1ns / 1ps

module tb_pid_heading_turn_controller_unit;
  import phtc_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HEAD_MAX = (1 << (HEAD_W - 1)) - 1;
  localparam int HEAD_MIN = -(1 << (HEAD_W - 1));
  localparam longint INTEG_HI = (64'sd1 <<< 31) - 1;
  localparam longint INTEG_LO = -(64'sd1 <<< 31);

  typedef struct {
    logic [DRIVE_W-1:0] drive;
    logic               left;
    logic               stop;
  } drive_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     action = ACT_START;
  logic signed [HEAD_W-1:0] measured_heading = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [DRIVE_W-1:0]       drive_mv;
  logic                     turn_left;
  logic                     stop;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [2:0]               paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;

  // predictor copy of the block state
  logic signed [HEAD_W-1:0] tgt_r = '0;
  logic                     gain_r = 1'b0;
  longint                   integ_r = 0;
  longint                   last_err_r = 0;
  int                       ticks_r = 0;
  int                       settle_r = 0;
  bit                       done_r = 1'b0;

  drive_t drive_q[$];
  bit     calm = 1'b0;
  int     sent_count = 0;
  int     mismatches = 0;
  int     quiet_cycles = 0;

  pid_heading_turn_controller_unit uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .action           (action),
    .measured_heading (measured_heading),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .drive_mv         (drive_mv),
    .turn_left        (turn_left),
    .stop             (stop),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 31);
  end

  function automatic void clear_turn();
    integ_r = 0;
    last_err_r = 0;
    ticks_r = 0;
    settle_r = 0;
    done_r = 1'b0;
  endfunction

  function automatic void predict_drive(logic [0:0] act, logic signed [HEAD_W-1:0] hdg);
    longint e, d, s, kp, ki, kd, ae;
    longint unsigned mag, mv;
    drive_t r;
    r = '{drive: '0, left: 1'b0, stop: 1'b0};
    if (act == ACT_START) begin
      clear_turn();
    end else if (done_r) begin
      r.stop = 1'b1;
    end else begin
      e = longint'(tgt_r) - longint'(hdg);
      ae = (e < 0) ? -e : e;
      if (ae <= longint'(TOL_STOP)) begin
        done_r = 1'b1;
        r.stop = 1'b1;
      end else begin
        if (ticks_r < MIN_TICKS_DEF + 1) ticks_r++;
        integ_r += e * 15;
        if (integ_r > INTEG_HI) integ_r = INTEG_HI;
        if (integ_r < INTEG_LO) integ_r = INTEG_LO;
        if (ae <= longint'(TOL_ICLR_LO) || ae >= longint'(TOL_ICLR_HI)) integ_r = 0;
        d = e - last_err_r;
        last_err_r = e;
        if (d >= -1 && d <= 1) begin
          if (settle_r < SETTLE_TICKS_DEF) settle_r++;
        end else begin
          settle_r = 0;
        end
        kp = gain_r ? longint'(KP1) : longint'(KP0);
        ki = gain_r ? longint'(KI1) : longint'(KI0);
        kd = gain_r ? longint'(KD1) : longint'(KD0);
        s = kp * e + ki * integ_r + kd * d;
        if (ticks_r > MIN_TICKS_DEF && settle_r >= SETTLE_TICKS_DEF) begin
          done_r = 1'b1;
          r.stop = 1'b1;
        end else begin
          mag = (s < 0) ? longint'(-s) : longint'(s);
          mv = (mag * 6 + 5 * (64'd1 << 23)) / (5 * (64'd1 << 24));
          if (mv > DRIVE_MAX) mv = DRIVE_MAX;
          r.drive = mv[DRIVE_W-1:0];
          r.left = (s < 0);
        end
      end
    end
    drive_q.push_back(r);
  endfunction

  always @(posedge clk) begin : result_check
    drive_t want;
    if (!rst && out_valid && out_ready) begin
      if (drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: drive_mv=%0d turn_left=%0b stop=%0b",
                   drive_mv, turn_left, stop);
      end else begin
        want = drive_q.pop_front();
        if (drive_mv !== want.drive || turn_left !== want.left || stop !== want.stop) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: drive_mv exp %0d got %0d, turn_left exp %0b got %0b,",
                      " stop exp %0b got %0b"},
                     want.drive, drive_mv, want.left, turn_left, want.stop, stop);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_pid_heading_turn_controller_unit NOT OK");
        $finish;
      end
    end
  end

  task automatic offer_cmd(logic [0:0] act, int hdg);
    logic signed [HEAD_W-1:0] h;
    h = HEAD_W'(hdg);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    measured_heading <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_drive(act, h);
    sent_count++;
  endtask

  // wait until every transaction has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TARGET: tgt_r = val[HEAD_W-1:0];
      REG_GAIN:   gain_r = val[0];
      default: ;
    endcase
  endtask

  function automatic int rand_span(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  task automatic test_start_and_tolerance();
    offer_cmd(ACT_START, 0);
    offer_cmd(ACT_TICK, 0);
    offer_cmd(ACT_TICK, 500);
    offer_cmd(ACT_START, -1);
    offer_cmd(ACT_TICK, -10);
    offer_cmd(ACT_START, 0);
    offer_cmd(ACT_TICK, 11);
    offer_cmd(ACT_TICK, -11);
  endtask

  task automatic test_integral_edges();
    write_reg(REG_GAIN, 32'd1);
    offer_cmd(ACT_START, 0);
    offer_cmd(ACT_TICK, -51);
    offer_cmd(ACT_TICK, -50);
    offer_cmd(ACT_TICK, -9999);
    offer_cmd(ACT_TICK, -10000);
    offer_cmd(ACT_TICK, 51);
    offer_cmd(ACT_TICK, 10000);
  endtask

  task automatic test_heading_extremes();
    write_reg(REG_TARGET, HEAD_MAX);
    offer_cmd(ACT_START, HEAD_MAX);
    offer_cmd(ACT_TICK, HEAD_MIN);
    write_reg(REG_TARGET, HEAD_MIN);
    offer_cmd(ACT_START, HEAD_MIN);
    offer_cmd(ACT_TICK, HEAD_MAX);
    write_reg(REG_GAIN, 32'd0);
    write_reg(REG_TARGET, 1000000);
    offer_cmd(ACT_START, 0);
    offer_cmd(ACT_TICK, -1000000);
  endtask

  task automatic test_settle();
    write_reg(REG_TARGET, 5000);
    offer_cmd(ACT_START, 0);
    for (int i = 0; i < 13; i++) offer_cmd(ACT_TICK, i % 2);
  endtask

  task automatic run_turn();
    int off;
    int n;
    bit steady;
    if ($urandom_range(9) != 0) offer_cmd(ACT_START, int'($urandom()));
    case ($urandom_range(3))
      0: off = rand_span(30);
      1: off = rand_span(300);
      2: off = rand_span(20000);
      default: off = rand_span(2000000);
    endcase
    steady = ($urandom_range(3) == 0);
    n = steady ? int'($urandom_range(10, 16)) : int'($urandom_range(1, 25));
    repeat (n) begin
      if (steady && $urandom_range(7) != 0) begin
        off = off + int'($urandom_range(2)) - 1;
        offer_cmd(ACT_TICK, int'(tgt_r) - off);
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: begin
            off = off - off / 4 + int'($urandom_range(4)) - 2;
            offer_cmd(ACT_TICK, int'(tgt_r) - off);
          end
          5, 6, 7: begin
            off = off + int'($urandom_range(2)) - 1;
            offer_cmd(ACT_TICK, int'(tgt_r) - off);
          end
          8: begin
            off = rand_span(12000);
            offer_cmd(ACT_TICK, int'(tgt_r) - off);
          end
          default: offer_cmd(logic'($urandom_range(1)), int'($urandom()));
        endcase
      end
    end
    if ($urandom_range(19) == 0) drain();
  endtask

  task automatic test_random_turns();
    int goal;
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(5))
        0: write_reg(REG_TARGET, HEAD_MIN);
        1: write_reg(REG_TARGET, HEAD_MAX);
        2: write_reg(REG_TARGET, -1000000);
        3: write_reg(REG_TARGET, 0);
        default: write_reg(REG_TARGET, rand_span(1000000));
      endcase
      write_reg(REG_GAIN, $urandom_range(1));
      calm = (phase == 3);
      goal = sent_count + 215;
      while (sent_count < goal) run_turn();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_start_and_tolerance();
    test_integral_edges();
    test_heading_extremes();
    test_settle();
    test_random_turns();
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("tb_pid_heading_turn_controller_unit OK");
    end else begin
      $display("tb_pid_heading_turn_controller_unit NOT OK");
    end
    $finish;
  end

endmodule
